### rtl/core/bsc_pkg.sv
// ----------------------------------------------------------------------------
// bsc_pkg
// Widths, constants and register indexes shared by the compensation core.
// ----------------------------------------------------------------------------
package bsc_pkg;

  localparam int RAW_W    = 24;
  localparam int COEF_W   = 16;
  localparam int TEMP_W   = 19;
  localparam int PRES_W   = 23;
  localparam int DT_W     = 25;
  localparam int TERM_W   = 42;
  localparam int OFF_W    = 38;
  localparam int SENS_W   = 36;
  localparam int SPLIT_W  = 18;
  localparam int PPLO_W   = RAW_W + SPLIT_W;
  localparam int PPHI_W   = RAW_W + 1 + (SENS_W - SPLIT_W);
  localparam int PROD_W   = 62;
  localparam int CFG_IDX_W = 3;

  localparam logic signed [TEMP_W:0] TEMP_BASE = 20'sd2000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SENS        = 3'd0,
    REG_OFFSET      = 3'd1,
    REG_SENS_TEMP   = 3'd2,
    REG_OFFSET_TEMP = 3'd3,
    REG_REF_TEMP    = 3'd4,
    REG_TEMP_SLOPE  = 3'd5
  } cfg_reg_t;

endpackage

### rtl/core/baro_sensor_compensation_core.sv
// ----------------------------------------------------------------------------
// baro_sensor_compensation_core
// First-order compensation of raw barometric pressure and temperature.
// ----------------------------------------------------------------------------
// The core accepts one beat per cycle while the output beat is not waiting, and
// raises out_tvalid for each result in order. The six register stages are the
// offset subtract, the three calibration products, the offset and sensitivity
// sums, two stages of the split pressure-times-sensitivity product, and the
// final subtract and shift into the output register. The whole pipeline holds
// while the output beat waits. The user is to write calibration words through
// the cfg port only between streams, when no beat is in flight; the core itself
// does not enforce this.
module baro_sensor_compensation_core (
  input  logic                              clk,
  input  logic                              rst_n,
  // [23:0] pressure_raw, [47:24] temperature_raw
  input  logic [47:0]                       in_tdata,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [18:0] temperature_centi_deg, [41:19] pressure_centi_mbar, [47:42] zero
  output logic [47:0]                       out_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bsc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bsc_pkg::COEF_W-1:0]        cfg_data
);

  logic [bsc_pkg::COEF_W-1:0] c1_r, c2_r, c3_r, c4_r, c5_r, c6_r;
  logic advance;
  logic v1_r, v2_r, v3_r, v4_r, v5_r, out_valid_r;

  logic [bsc_pkg::RAW_W-1:0]                d1_in, d2_in;
  logic [bsc_pkg::RAW_W-1:0]                d1_1_r, d1_2_r, d1_3_r;
  logic signed [bsc_pkg::DT_W-1:0]          dt_nxt, dt_1_r;
  logic signed [bsc_pkg::TERM_W-1:0]        p_off_nxt, p_sens_nxt, p_temp_nxt;
  logic signed [bsc_pkg::TERM_W-1:0]        p_off_2_r, p_sens_2_r, p_temp_2_r;
  logic signed [bsc_pkg::OFF_W-1:0]         off_nxt, off_3_r, off_4_r, off_5_r;
  logic signed [bsc_pkg::SENS_W-1:0]        sens_nxt, sens_3_r;
  logic signed [bsc_pkg::TEMP_W:0]          temp_nxt;
  logic [bsc_pkg::TEMP_W-1:0]               temp_3_r, temp_4_r, temp_5_r, temp_out_r;
  logic signed [bsc_pkg::PROD_W-1:0]        prod_5;
  logic signed [bsc_pkg::OFF_W+3:0]         pres_diff;
  logic [bsc_pkg::PRES_W-1:0]               pres_out_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_r <= '0;
      c2_r <= '0;
      c3_r <= '0;
      c4_r <= '0;
      c5_r <= '0;
      c6_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        bsc_pkg::REG_SENS:        c1_r <= cfg_data;
        bsc_pkg::REG_OFFSET:      c2_r <= cfg_data;
        bsc_pkg::REG_SENS_TEMP:   c3_r <= cfg_data;
        bsc_pkg::REG_OFFSET_TEMP: c4_r <= cfg_data;
        bsc_pkg::REG_REF_TEMP:    c5_r <= cfg_data;
        bsc_pkg::REG_TEMP_SLOPE:  c6_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign advance   = !out_valid_r || out_tready;
  assign in_tready = advance;

  assign d1_in  = in_tdata[23:0];
  assign d2_in  = in_tdata[47:24];
  assign dt_nxt = $signed({1'b0, d2_in}) - $signed({1'b0, c5_r, 8'b0});

  assign p_off_nxt  = $signed({1'b0, c4_r}) * dt_1_r;
  assign p_sens_nxt = $signed({1'b0, c3_r}) * dt_1_r;
  assign p_temp_nxt = $signed({1'b0, c6_r}) * dt_1_r;

  assign off_nxt  = $signed({5'b0, c2_r, 17'b0})
                  + $signed({{2{p_off_2_r[bsc_pkg::TERM_W-1]}},
                             p_off_2_r[bsc_pkg::TERM_W-1:6]});
  assign sens_nxt = $signed({4'b0, c1_r, 16'b0})
                  + $signed({p_sens_2_r[bsc_pkg::TERM_W-1],
                             p_sens_2_r[bsc_pkg::TERM_W-1:7]});
  assign temp_nxt = bsc_pkg::TEMP_BASE
                  + $signed({p_temp_2_r[bsc_pkg::TERM_W-1],
                             p_temp_2_r[bsc_pkg::TERM_W-1:23]});

  bsc_pres_mul u_pres_mul (
    .clk  (clk),
    .en   (advance),
    .d1   (d1_3_r),
    .sens (sens_3_r),
    .prod (prod_5)
  );

  assign pres_diff = $signed({prod_5[bsc_pkg::PROD_W-1], prod_5[bsc_pkg::PROD_W-1:21]})
                   - $signed({{4{off_5_r[bsc_pkg::OFF_W-1]}}, off_5_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      v1_r        <= in_tvalid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      v5_r        <= v4_r;
      out_valid_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      d1_1_r     <= d1_in;
      dt_1_r     <= dt_nxt;
      d1_2_r     <= d1_1_r;
      p_off_2_r  <= p_off_nxt;
      p_sens_2_r <= p_sens_nxt;
      p_temp_2_r <= p_temp_nxt;
      d1_3_r     <= d1_2_r;
      off_3_r    <= off_nxt;
      sens_3_r   <= sens_nxt;
      temp_3_r   <= temp_nxt[bsc_pkg::TEMP_W-1:0];
      off_4_r    <= off_3_r;
      temp_4_r   <= temp_3_r;
      off_5_r    <= off_4_r;
      temp_5_r   <= temp_4_r;
      temp_out_r <= temp_5_r;
      pres_out_r <= pres_diff[bsc_pkg::PRES_W+14:15];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, pres_out_r, temp_out_r};

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> v1_r)
    else $error("accepted beat did not enter the pipeline");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |=> $stable({v1_r, v2_r, v3_r, v4_r, v5_r, out_valid_r}))
    else $error("pipeline valid bits moved during a stall");

  a_last_stage_lands: assert property (@(posedge clk) disable iff (!rst_n)
    v5_r && in_tready |=> out_valid_r)
    else $error("last stage beat did not reach the output register");

endmodule

### rtl/core/bsc_pres_mul.sv
// ----------------------------------------------------------------------------
// bsc_pres_mul
// Two-stage product of the raw pressure and the signed sensitivity, built
// from two partial products that are summed in the second stage.
// ----------------------------------------------------------------------------
module bsc_pres_mul (
  input  logic                                    clk,
  input  logic                                    en,
  input  logic [bsc_pkg::RAW_W-1:0]               d1,
  input  logic signed [bsc_pkg::SENS_W-1:0]       sens,
  output logic signed [bsc_pkg::PROD_W-1:0]       prod
);

  logic [bsc_pkg::SPLIT_W-1:0]                      sens_lo;
  logic signed [bsc_pkg::SENS_W-bsc_pkg::SPLIT_W-1:0] sens_hi;
  logic [bsc_pkg::PPLO_W-1:0]                       pp_lo_nxt, pp_lo_r;
  logic signed [bsc_pkg::PPHI_W-1:0]                pp_hi_nxt, pp_hi_r;
  logic signed [bsc_pkg::PROD_W-1:0]                hi_ext, lo_ext, prod_nxt, prod_r;

  assign sens_lo   = sens[bsc_pkg::SPLIT_W-1:0];
  assign sens_hi   = sens[bsc_pkg::SENS_W-1:bsc_pkg::SPLIT_W];
  assign pp_lo_nxt = d1 * sens_lo;
  assign pp_hi_nxt = $signed({1'b0, d1}) * sens_hi;

  assign hi_ext   = {{(bsc_pkg::PROD_W - bsc_pkg::PPHI_W - bsc_pkg::SPLIT_W)
                      {pp_hi_r[bsc_pkg::PPHI_W-1]}},
                     pp_hi_r, {bsc_pkg::SPLIT_W{1'b0}}};
  assign lo_ext   = $signed({{(bsc_pkg::PROD_W - bsc_pkg::PPLO_W){1'b0}}, pp_lo_r});
  assign prod_nxt = hi_ext + lo_ext;

  always_ff @(posedge clk) begin
    if (en) begin
      pp_lo_r <= pp_lo_nxt;
      pp_hi_r <= pp_hi_nxt;
      prod_r  <= prod_nxt;
    end
  end

  assign prod = prod_r;

endmodule

### tb/tb_baro_sensor_compensation_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_baro_sensor_compensation_core
// Self-checking testbench for the barometric compensation core. A directed
// table covers reset values, field extremes, ignored register indexes and a
// set of typical calibration words. Randomized phases follow, each with its
// own calibration set. An independent fixed-point predictor checks all untyped
// results, with random stalls on both streams and a long output back-pressure.
// ----------------------------------------------------------------------------
module tb_baro_sensor_compensation_core;

  localparam int TDATA_W     = 48;
  localparam int STALL_LIMIT = 4000;
  localparam int PHASES      = 8;
  localparam int PHASE_BEATS = 104;
  localparam int HOLD_CYCLES = 300;
  localparam int DIR_ROWS    = 39;

  localparam logic [bsc_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [bsc_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [bsc_pkg::TEMP_W-1:0] t;
    logic [bsc_pkg::PRES_W-1:0] p;
  } comp_result_t;

  typedef enum logic {ROW_CAL, ROW_BEAT} row_op_t;

  typedef struct packed {
    row_op_t                       op;
    logic [bsc_pkg::CFG_IDX_W-1:0] idx;
    logic [bsc_pkg::COEF_W-1:0]    word;
    logic [bsc_pkg::RAW_W-1:0]     d1;
    logic [bsc_pkg::RAW_W-1:0]     d2;
    logic                          typed;
    logic [bsc_pkg::TEMP_W-1:0]    t;
    logic [bsc_pkg::PRES_W-1:0]    p;
  } dir_row_t;

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic [TDATA_W-1:0]            in_tdata;
  logic                          in_tvalid;
  logic                          in_tready;
  logic [TDATA_W-1:0]            out_tdata;
  logic                          out_tvalid;
  logic                          out_tready;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [bsc_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [bsc_pkg::COEF_W-1:0]    cfg_data;

  logic [bsc_pkg::COEF_W-1:0] cal_word [6];
  comp_result_t      pending_results [$];
  comp_result_t      due;
  int                fail_count = 0;
  bit                tx_gaps = 1'b1;
  bit                rx_gaps = 1'b1;
  bit                hold_req = 1'b0;
  int                hold_left = 0;

  dir_row_t dir_rows [DIR_ROWS] = '{
    '{ROW_CAL,  CFG_SPARE_LO, 16'hFFFF, 24'h0, 24'h0, 1'b0, 19'd0, 23'd0},
    '{ROW_CAL,  CFG_SPARE_HI, 16'hA5A5, 24'h0, 24'h0, 1'b0, 19'd0, 23'd0},
    '{ROW_BEAT, 3'd0, 16'd0, 24'h000000, 24'h000000, 1'b1, 19'd2000, 23'd0},
    '{ROW_BEAT, 3'd0, 16'd0, 24'hFFFFFF, 24'hFFFFFF, 1'b1, 19'd2000, 23'd0},
    '{ROW_BEAT, 3'd0, 16'd0, 24'hFFFFFF, 24'h000000, 1'b1, 19'd2000, 23'd0},
    '{ROW_BEAT, 3'd0, 16'd0, 24'h000000, 24'hFFFFFF, 1'b1, 19'd2000, 23'd0},
    '{ROW_BEAT, 3'd0, 16'd0, 24'hAAAAAA, 24'h555555, 1'b1, 19'd2000, 23'd0},
    '{ROW_BEAT, 3'd0, 16'd0, 24'h555555, 24'hAAAAAA, 1'b1, 19'd2000, 23'd0},
    '{ROW_CAL, bsc_pkg::REG_SENS,        16'd40127, 24'h0, 24'h0, 1'b0, 19'd0, 23'd0},
    '{ROW_CAL, bsc_pkg::REG_OFFSET,      16'd36924, 24'h0, 24'h0, 1'b0, 19'd0, 23'd0},
    '{ROW_CAL, bsc_pkg::REG_SENS_TEMP,   16'd23317, 24'h0, 24'h0, 1'b0, 19'd0, 23'd0},
    '{ROW_CAL, bsc_pkg::REG_OFFSET_TEMP, 16'd23282, 24'h0, 24'h0, 1'b0, 19'd0, 23'd0},
    '{ROW_CAL, bsc_pkg::REG_REF_TEMP,    16'd33464, 24'h0, 24'h0, 1'b0, 19'd0, 23'd0},
    '{ROW_CAL, bsc_pkg::REG_TEMP_SLOPE,  16'd28312, 24'h0, 24'h0, 1'b0, 19'd0, 23'd0},
    '{ROW_BEAT, 3'd0, 16'd0, 24'd9085466, 24'd8569150, 1'b0, 19'd0, 23'd0},
    '{ROW_BEAT, 3'd0, 16'd0, 24'h000000, 24'h000000, 1'b0, 19'd0, 23'd0},
    '{ROW_BEAT, 3'd0, 16'd0, 24'hFFFFFF, 24'hFFFFFF, 1'b0, 19'd0, 23'd0},
    '{ROW_BEAT, 3'd0, 16'd0, 24'hFFFFFF, 24'h000000, 1'b0, 19'd0, 23'd0},
    '{ROW_CAL, bsc_pkg::REG_SENS,        16'hFFFF, 24'h0, 24'h0, 1'b0, 19'd0, 23'd0},
    '{ROW_CAL, bsc_pkg::REG_OFFSET,      16'hFFFF, 24'h0, 24'h0, 1'b0, 19'd0, 23'd0},
    '{ROW_CAL, bsc_pkg::REG_SENS_TEMP,   16'hFFFF, 24'h0, 24'h0, 1'b0, 19'd0, 23'd0},
    '{ROW_CAL, bsc_pkg::REG_OFFSET_TEMP, 16'hFFFF, 24'h0, 24'h0, 1'b0, 19'd0, 23'd0},
    '{ROW_CAL, bsc_pkg::REG_REF_TEMP,    16'hFFFF, 24'h0, 24'h0, 1'b0, 19'd0, 23'd0},
    '{ROW_CAL, bsc_pkg::REG_TEMP_SLOPE,  16'hFFFF, 24'h0, 24'h0, 1'b0, 19'd0, 23'd0},
    '{ROW_BEAT, 3'd0, 16'd0, 24'h000000, 24'h000000, 1'b0, 19'd0, 23'd0},
    '{ROW_BEAT, 3'd0, 16'd0, 24'hFFFFFF, 24'hFFFFFF, 1'b0, 19'd0, 23'd0},
    '{ROW_BEAT, 3'd0, 16'd0, 24'hFFFFFF, 24'h000000, 1'b0, 19'd0, 23'd0},
    '{ROW_BEAT, 3'd0, 16'd0, 24'h000000, 24'hFFFFFF, 1'b0, 19'd0, 23'd0},
    '{ROW_BEAT, 3'd0, 16'd0, 24'h800000, 24'hFFFF00, 1'b0, 19'd0, 23'd0},
    '{ROW_CAL, bsc_pkg::REG_SENS,        16'h0000, 24'h0, 24'h0, 1'b0, 19'd0, 23'd0},
    '{ROW_CAL, bsc_pkg::REG_OFFSET,      16'h0000, 24'h0, 24'h0, 1'b0, 19'd0, 23'd0},
    '{ROW_BEAT, 3'd0, 16'd0, 24'hFFFFFF, 24'h000000, 1'b0, 19'd0, 23'd0},
    '{ROW_BEAT, 3'd0, 16'd0, 24'hFFFFFF, 24'hFFFFFF, 1'b0, 19'd0, 23'd0},
    '{ROW_BEAT, 3'd0, 16'd0, 24'h000001, 24'h000000, 1'b0, 19'd0, 23'd0},
    '{ROW_CAL, bsc_pkg::REG_SENS,        16'hFFFF, 24'h0, 24'h0, 1'b0, 19'd0, 23'd0},
    '{ROW_CAL, bsc_pkg::REG_SENS_TEMP,   16'h0000, 24'h0, 24'h0, 1'b0, 19'd0, 23'd0},
    '{ROW_CAL, bsc_pkg::REG_REF_TEMP,    16'h0000, 24'h0, 24'h0, 1'b0, 19'd0, 23'd0},
    '{ROW_BEAT, 3'd0, 16'd0, 24'hFFFFFF, 24'hFFFFFF, 1'b0, 19'd0, 23'd0},
    '{ROW_BEAT, 3'd0, 16'd0, 24'hFFFFFF, 24'h000000, 1'b0, 19'd0, 23'd0}
  };

  baro_sensor_compensation_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint coef(bsc_pkg::cfg_reg_t r);
    return longint'({48'd0, cal_word[r]});
  endfunction

  function automatic comp_result_t compensate(logic [bsc_pkg::RAW_W-1:0] d1_raw,
                                              logic [bsc_pkg::RAW_W-1:0] d2_raw);
    longint d1, d2, dt, off, sens, temp, pres;
    comp_result_t r;
    d1   = longint'({40'd0, d1_raw});
    d2   = longint'({40'd0, d2_raw});
    dt   = d2 - coef(bsc_pkg::REG_REF_TEMP) * 256;
    off  = coef(bsc_pkg::REG_OFFSET) * 131072
         + ((coef(bsc_pkg::REG_OFFSET_TEMP) * dt) >>> 6);
    sens = coef(bsc_pkg::REG_SENS) * 65536 + ((coef(bsc_pkg::REG_SENS_TEMP) * dt) >>> 7);
    temp = longint'(bsc_pkg::TEMP_BASE) + ((dt * coef(bsc_pkg::REG_TEMP_SLOPE)) >>> 23);
    pres = (((d1 * sens) >>> 21) - off) >>> 15;
    r.t  = temp[bsc_pkg::TEMP_W-1:0];
    r.p  = pres[bsc_pkg::PRES_W-1:0];
    return r;
  endfunction

  task automatic offer_beat(logic [bsc_pkg::RAW_W-1:0] d1, logic [bsc_pkg::RAW_W-1:0] d2,
                            bit typed, comp_result_t typed_res);
    while (tx_gaps && $urandom_range(99) < 28) begin
      @(negedge clk);
      in_tvalid = 1'b0;
    end
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tdata  = {d2, d1};
    do @(posedge clk); while (!in_tready);
    if (typed) begin
      pending_results.push_back(typed_res);
    end else begin
      pending_results.push_back(compensate(d1, d2));
    end
  endtask

  task automatic end_stream();
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic drain_results();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_cal(logic [bsc_pkg::CFG_IDX_W-1:0] idx,
                           logic [bsc_pkg::COEF_W-1:0] word);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = word;
    do @(posedge clk); while (!cfg_ready);
    if (idx <= bsc_pkg::REG_TEMP_SLOPE) begin
      cal_word[idx] = word;
    end
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready = 1'b0;
      end else begin
        out_tready = !(rx_gaps && $urandom_range(99) < 28);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("result beat with no expectation waiting: tdata=%h", out_tdata);
        fail_count++;
      end else begin
        due = pending_results.pop_front();
        if (out_tdata[bsc_pkg::TEMP_W-1:0] !== due.t) begin
          $error("temperature_centi_deg: expected %0d, got %0d",
                 $signed(due.t), $signed(out_tdata[bsc_pkg::TEMP_W-1:0]));
          fail_count++;
        end
        if (out_tdata[bsc_pkg::TEMP_W+bsc_pkg::PRES_W-1:bsc_pkg::TEMP_W] !== due.p) begin
          $error("pressure_centi_mbar: expected %0d, got %0d", $signed(due.p),
                 $signed(out_tdata[bsc_pkg::TEMP_W+bsc_pkg::PRES_W-1:bsc_pkg::TEMP_W]));
          fail_count++;
        end
        if (out_tdata[TDATA_W-1:bsc_pkg::TEMP_W+bsc_pkg::PRES_W] !== '0) begin
          $error("tdata padding: expected 0, got %h",
                 out_tdata[TDATA_W-1:bsc_pkg::TEMP_W+bsc_pkg::PRES_W]);
          fail_count++;
        end
      end
    end
  end

  initial begin
    int stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_valid && cfg_ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    dir_row_t                   row;
    comp_result_t               typed_res;
    logic [bsc_pkg::RAW_W-1:0]  d1;
    logic [bsc_pkg::RAW_W-1:0]  d2;
    logic [bsc_pkg::COEF_W-1:0] word;
    int                         near;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    foreach (cal_word[i]) cal_word[i] = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i < DIR_ROWS; i++) begin
      row = dir_rows[i];
      if (row.op == ROW_CAL) begin
        end_stream();
        drain_results();
        write_cal(row.idx, row.word);
      end else begin
        typed_res.t = row.t;
        typed_res.p = row.p;
        offer_beat(row.d1, row.d2, row.typed, typed_res);
      end
    end
    end_stream();
    drain_results();

    for (int ph = 0; ph < PHASES; ph++) begin
      for (int r = 0; r < 6; r++) begin
        if (ph == 0) begin
          word = 16'hFFFF;
        end else if (ph == 1) begin
          word = 16'h0000;
        end else begin
          case ($urandom_range(9))
            0: word = 16'h0000;
            1: word = 16'hFFFF;
            default: word = 16'($urandom_range(16'hFFFF));
          endcase
        end
        write_cal(r[bsc_pkg::CFG_IDX_W-1:0], word);
      end
      if (ph == 2) begin
        write_cal(CFG_SPARE_HI, 16'($urandom_range(16'hFFFF)));
        write_cal(CFG_SPARE_LO, 16'($urandom_range(16'hFFFF)));
      end
      tx_gaps = (ph != 4);
      rx_gaps = (ph != 4);
      if (ph == 3) begin
        hold_req = 1'b1;
      end
      for (int n = 0; n < PHASE_BEATS; n++) begin
        if (ph == 5 && n == PHASE_BEATS / 2) begin
          end_stream();
          drain_results();
        end
        case ($urandom_range(9))
          0, 1, 2, 3, 4: begin
            d1   = 24'($urandom_range(24'hFFFFFF));
            near = int'(cal_word[bsc_pkg::REG_REF_TEMP]) * 256 - 65536;
            near = near + int'($urandom_range(131071));
            if (near < 0) near = 0;
            if (near > 24'hFFFFFF) near = 24'hFFFFFF;
            d2 = near[bsc_pkg::RAW_W-1:0];
          end
          5, 6, 7: begin
            d1 = 24'($urandom);
            d2 = 24'($urandom);
          end
          8: begin
            d1 = $urandom_range(1) ? 24'hFFFFFF : 24'h000000;
            d2 = $urandom_range(1) ? 24'hFFFFFF : 24'h000000;
          end
          default: begin
            d1 = 24'h1 << $urandom_range(bsc_pkg::RAW_W - 1);
            d2 = ~(24'h1 << $urandom_range(bsc_pkg::RAW_W - 1));
          end
        endcase
        offer_beat(d1, d2, 1'b0, typed_res);
      end
      end_stream();
      drain_results();
      tx_gaps = 1'b1;
      rx_gaps = 1'b1;
    end

    repeat (12) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
